FILE: rtl/text_cell_glyph_renderer_unit_macros.svh
// ----------------------------------------------------------------------------
// Text cell glyph renderer assertion macros
// Shared helpers for the concurrent checks in the renderer modules.
// ----------------------------------------------------------------------------
`ifndef TEXT_CELL_GLYPH_RENDERER_UNIT_MACROS_SVH
`define TEXT_CELL_GLYPH_RENDERER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define TCGR_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define TCGR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/tcgr_pkg.sv
// ----------------------------------------------------------------------------
// Text cell glyph renderer package
// Shared widths, register indexes, palette and controller command types.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam int FONT_DEPTH     = 4096;
    localparam int FONT_AW        = 12;
    localparam int COLOR_W        = 24;
    localparam int ADDR_W         = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;
    localparam int PAIRS_PER_LINE = 4;
    localparam int PAIR_W         = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_ADDRESS    = 2'd0,
        REG_LINE_PITCH      = 2'd1,
        REG_BYTES_PER_PIXEL = 2'd2
    } t_reg_idx;

    typedef enum logic {
        ACT_RENDER    = 1'b0,
        ACT_FONT_LOAD = 1'b1
    } t_action;

    localparam logic [COLOR_W-1:0] PALETTE [16] = '{
        24'h000000, 24'h0000AA, 24'h00AA00, 24'h00AAAA,
        24'hAA0000, 24'hAA00AA, 24'hAA5000, 24'hAAAAAA,
        24'h555555, 24'h5555FF, 24'h55FF55, 24'h55FFFF,
        24'hFF5555, 24'hFF55FF, 24'hFFFF55, 24'hFFFFFF
    };

    typedef struct packed {
        logic              capture;
        logic              font_wr;
        logic              mul;
        logic              sum;
        logic              emit;
        logic              line_end;
        logic              last;
        logic              rd_en;
        logic [PAIR_W-1:0] pair;
    } t_dp_cmd;

    typedef struct packed {
        logic slot_free;
    } t_dp_status;

endpackage

FILE: rtl/tcgr_cell_if.sv
// ----------------------------------------------------------------------------
// Text cell channel
// Carries one text cell or one font byte per word.
// ----------------------------------------------------------------------------
interface tcgr_cell_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [7:0]  char_code;
    logic [7:0]  attribute;
    logic [7:0]  column;
    logic [7:0]  row;
    logic        cursor;
    logic [11:0] font_index;
    logic [7:0]  font_byte;

    modport source (
        output valid, action, char_code, attribute, column, row, cursor,
               font_index, font_byte,
        input  ready
    );
    modport sink (
        input  valid, action, char_code, attribute, column, row, cursor,
               font_index, font_byte,
        output ready
    );
endinterface

FILE: rtl/tcgr_pix_if.sv
// ----------------------------------------------------------------------------
// Pixel pair channel
// Carries one pixel pair write per word.
// ----------------------------------------------------------------------------
interface tcgr_pix_if;
    logic        valid;
    logic        ready;
    logic [31:0] pixel_address;
    logic [23:0] left_color;
    logic [23:0] right_color;
    logic        last;

    modport source (
        output valid, pixel_address, left_color, right_color, last,
        input  ready
    );
    modport sink (
        input  valid, pixel_address, left_color, right_color, last,
        output ready
    );
endinterface

FILE: rtl/tcgr_ctrl.sv
// ----------------------------------------------------------------------------
// Text cell glyph renderer controller
// Sequences cell setup and walks glyph lines and pixel pairs.
// ----------------------------------------------------------------------------
`include "text_cell_glyph_renderer_unit_macros.svh"

module tcgr_ctrl #(
    parameter int GLYPH_HEIGHT = 16,
    parameter int LW           = $clog2(GLYPH_HEIGHT)
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    input  logic                 i_action,
    output logic                 o_ready,
    input  tcgr_pkg::t_dp_status i_status,
    output tcgr_pkg::t_dp_cmd    o_cmd,
    output logic [LW-1:0]        o_rd_line
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MUL,
        S_SUM,
        S_RUN
    } t_state;

    t_state                      r_state;
    logic [LW-1:0]               r_line;
    logic [tcgr_pkg::PAIR_W-1:0] r_pair;
    logic                        accept;
    logic                        advance;
    logic                        line_end;
    logic                        last_pair;

    assign o_ready   = (r_state == S_IDLE);
    assign accept    = i_valid && o_ready;
    assign advance   = (r_state == S_RUN) && i_status.slot_free;
    assign line_end  = (r_pair == tcgr_pkg::PAIR_W'(tcgr_pkg::PAIRS_PER_LINE - 1));
    assign last_pair = line_end && (r_line == LW'(GLYPH_HEIGHT - 1));

    always_comb begin
        o_cmd          = '0;
        o_cmd.capture  = accept && (i_action == tcgr_pkg::ACT_RENDER);
        o_cmd.font_wr  = accept && (i_action == tcgr_pkg::ACT_FONT_LOAD);
        o_cmd.mul      = (r_state == S_MUL);
        o_cmd.sum      = (r_state == S_SUM);
        o_cmd.emit     = advance;
        o_cmd.line_end = line_end;
        o_cmd.last     = last_pair;
        o_cmd.pair     = r_pair;
        o_cmd.rd_en    = (r_state == S_SUM) || (advance && line_end && !last_pair);
        o_rd_line      = (r_state == S_SUM) ? '0 : r_line + LW'(1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_line  <= '0;
            r_pair  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_action == tcgr_pkg::ACT_RENDER)) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_SUM;
                end
                S_SUM: begin
                    r_state <= S_RUN;
                end
                S_RUN: begin
                    if (advance) begin
                        r_pair <= r_pair + tcgr_pkg::PAIR_W'(1);
                        if (last_pair) begin
                            r_line  <= '0;
                            r_state <= S_IDLE;
                        end else if (line_end) begin
                            r_line <= r_line + LW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    `TCGR_ASSERT_NEXT(a_cell_setup_starts, i_clk, i_rst_n, o_cmd.capture, r_state == S_MUL && r_line == '0 && r_pair == '0, "Cell setup did not start from the first pair.")
    `TCGR_ASSERT_NEXT(a_last_pair_ends_cell, i_clk, i_rst_n, o_cmd.emit && o_cmd.last, r_state == S_IDLE, "Controller did not return to idle after the last pair.")
    `TCGR_ASSERT_IMPL(a_idle_counters_clear, i_clk, i_rst_n, r_state == S_IDLE, r_line == '0 && r_pair == '0, "Line or pair counter left non-zero while idle.")

endmodule

FILE: rtl/tcgr_dp.sv
// ----------------------------------------------------------------------------
// Text cell glyph renderer datapath
// Font store, configuration, address arithmetic and the pixel pair register.
// ----------------------------------------------------------------------------
`include "text_cell_glyph_renderer_unit_macros.svh"

module tcgr_dp #(
    parameter int GLYPH_HEIGHT = 16,
    parameter int LW           = $clog2(GLYPH_HEIGHT)
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    input  logic [7:0]                          i_char_code,
    input  logic [7:0]                          i_attribute,
    input  logic [7:0]                          i_column,
    input  logic [7:0]                          i_row,
    input  logic                                i_cursor,
    input  logic [tcgr_pkg::FONT_AW-1:0]        i_font_index,
    input  logic [7:0]                          i_font_byte,
    input  tcgr_pkg::t_dp_cmd                   i_cmd,
    input  logic [LW-1:0]                       i_rd_line,
    output tcgr_pkg::t_dp_status                o_status,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [tcgr_pkg::ADDR_W-1:0]         o_pixel_address,
    output logic [tcgr_pkg::COLOR_W-1:0]        o_left_color,
    output logic [tcgr_pkg::COLOR_W-1:0]        o_right_color,
    output logic                                o_last
);

    localparam int YW = 8 + $clog2(GLYPH_HEIGHT);

    logic [7:0]                       mem [tcgr_pkg::FONT_DEPTH];
    logic [7:0]                       r_rd_data;

    logic [tcgr_pkg::ADDR_W-1:0]      r_base;
    logic [15:0]                      r_pitch;
    logic [2:0]                       r_bpp;

    logic                             r_blank;
    logic [tcgr_pkg::COLOR_W-1:0]     r_fg;
    logic [tcgr_pkg::COLOR_W-1:0]     r_bg;
    logic [tcgr_pkg::FONT_AW-1:0]     r_glyph_base;
    logic [10:0]                      r_x0;
    logic [YW-1:0]                    r_y0;
    logic [13:0]                      r_xoff;
    logic [YW+15:0]                   r_yoff;
    logic [tcgr_pkg::ADDR_W-1:0]      r_line_addr;
    logic [tcgr_pkg::ADDR_W-1:0]      r_pix_addr;

    logic                             r_out_valid;
    logic [tcgr_pkg::ADDR_W-1:0]      r_pixel_address;
    logic [tcgr_pkg::COLOR_W-1:0]     r_left_color;
    logic [tcgr_pkg::COLOR_W-1:0]     r_right_color;
    logic                             r_last;

    logic [tcgr_pkg::FONT_AW-1:0]     rd_addr;
    logic [7:0]                       bits;
    logic [7:0]                       shifted;
    logic [tcgr_pkg::COLOR_W-1:0]     fg_sel;
    logic [tcgr_pkg::COLOR_W-1:0]     bg_sel;
    logic [tcgr_pkg::ADDR_W-1:0]      next_line_addr;

    assign rd_addr        = r_glyph_base + tcgr_pkg::FONT_AW'(i_rd_line);
    assign bits           = r_blank ? 8'h00 : r_rd_data;
    assign shifted        = bits << {i_cmd.pair, 1'b0};
    assign fg_sel         = tcgr_pkg::PALETTE[i_attribute[3:0]];
    assign bg_sel         = tcgr_pkg::PALETTE[{1'b0, i_attribute[6:4]}];
    assign next_line_addr = r_line_addr + tcgr_pkg::ADDR_W'(r_pitch);

    assign o_status.slot_free = !r_out_valid || i_out_ready;
    assign o_out_valid        = r_out_valid;
    assign o_pixel_address    = r_pixel_address;
    assign o_left_color       = r_left_color;
    assign o_right_color      = r_right_color;
    assign o_last             = r_last;

    always_ff @(posedge i_clk) begin
        if (i_cmd.font_wr) begin
            mem[i_font_index] <= i_font_byte;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base  <= '0;
            r_pitch <= 16'd3072;
            r_bpp   <= 3'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                tcgr_pkg::REG_BASE_ADDRESS:    r_base  <= i_cfg_data;
                tcgr_pkg::REG_LINE_PITCH:      r_pitch <= i_cfg_data[15:0];
                tcgr_pkg::REG_BYTES_PER_PIXEL: r_bpp   <= i_cfg_data[2:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_blank      <= (i_char_code == 8'd0);
            r_fg         <= i_cursor ? bg_sel : fg_sel;
            r_bg         <= i_cursor ? fg_sel : bg_sel;
            r_glyph_base <= tcgr_pkg::FONT_AW'(i_char_code * GLYPH_HEIGHT);
            r_x0         <= {i_column, 3'b000};
            r_y0         <= YW'(i_row * GLYPH_HEIGHT);
        end
        if (i_cmd.mul) begin
            r_xoff <= 14'(r_x0) * 14'(r_bpp);
            r_yoff <= (YW+16)'(r_y0) * (YW+16)'(r_pitch);
        end
        if (i_cmd.sum) begin
            r_line_addr <= r_base + tcgr_pkg::ADDR_W'(r_xoff)
                         + tcgr_pkg::ADDR_W'(r_yoff);
            r_pix_addr  <= r_base + tcgr_pkg::ADDR_W'(r_xoff)
                         + tcgr_pkg::ADDR_W'(r_yoff);
        end else if (i_cmd.emit) begin
            if (i_cmd.line_end) begin
                r_line_addr <= next_line_addr;
                r_pix_addr  <= next_line_addr;
            end else begin
                r_pix_addr <= r_pix_addr + tcgr_pkg::ADDR_W'({r_bpp, 1'b0});
            end
        end
        if (i_cmd.emit) begin
            r_pixel_address <= r_pix_addr;
            r_left_color    <= shifted[7] ? r_fg : r_bg;
            r_right_color   <= shifted[6] ? r_fg : r_bg;
            r_last          <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    `TCGR_ASSERT_NEXT(a_emit_shows_word, i_clk, i_rst_n, i_cmd.emit, r_out_valid, "An emitted pixel pair word was not presented.")
    `TCGR_ASSERT_IMPL(a_emit_has_slot, i_clk, i_rst_n, i_cmd.emit, !r_out_valid || i_out_ready, "A pixel pair word was overwritten before it was taken.")

endmodule

FILE: rtl/text_cell_glyph_renderer_unit.sv
// ----------------------------------------------------------------------------
// Text cell glyph renderer
// Expands 16-colour text cells into 24-bit RGB pixel pair writes.
// ----------------------------------------------------------------------------
// A word on the cell channel either loads one byte into the 4096-byte font
// store or renders one cell. A cell is captured, then its address products
// are multiplied and summed, then it yields 4 * GLYPH_HEIGHT pixel pair words,
// one per cycle through the output register while the sink does not stall;
// the next word is taken in the cycle after the last pair is issued. The font
// store is read one glyph line ahead. Font bytes read before they are loaded
// are undefined. Configuration registers may be written only while idle.
module text_cell_glyph_renderer_unit #(
    parameter int GLYPH_HEIGHT = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [tcgr_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [tcgr_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    tcgr_cell_if.sink                           i_cell,
    tcgr_pix_if.source                          o_pix
);

    localparam int LW = $clog2(GLYPH_HEIGHT);

    tcgr_pkg::t_dp_cmd    cmd;
    tcgr_pkg::t_dp_status status;
    logic [LW-1:0]        rd_line;
    logic                 cell_ready;

    assign i_cell.ready = cell_ready;

    tcgr_ctrl #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .LW           (LW)
    ) u_ctrl (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_cell.valid),
        .i_action  (i_cell.action),
        .o_ready   (cell_ready),
        .i_status  (status),
        .o_cmd     (cmd),
        .o_rd_line (rd_line)
    );

    tcgr_dp #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT),
        .LW           (LW)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_char_code     (i_cell.char_code),
        .i_attribute     (i_cell.attribute),
        .i_column        (i_cell.column),
        .i_row           (i_cell.row),
        .i_cursor        (i_cell.cursor),
        .i_font_index    (i_cell.font_index),
        .i_font_byte     (i_cell.font_byte),
        .i_cmd           (cmd),
        .i_rd_line       (rd_line),
        .o_status        (status),
        .i_out_ready     (o_pix.ready),
        .o_out_valid     (o_pix.valid),
        .o_pixel_address (o_pix.pixel_address),
        .o_left_color    (o_pix.left_color),
        .o_right_color   (o_pix.right_color),
        .o_last          (o_pix.last)
    );

endmodule
